>>> sv/rfpwd_pkg.sv
// Shared types and constants of the pulse-width frame decoder.
package rfpwd_pkg;

    localparam int DUR_W       = 20;
    localparam int TOL_W       = 7;
    localparam int MINP_W      = 6;
    localparam int PAIR_W      = 6;
    localparam int NET_W       = 3;
    localparam int MAGIC_W     = 16;
    localparam int ADDR_W      = 4;
    localparam int NET_LSB     = 20;
    localparam int MAGIC_LSB   = 4;
    localparam int ADDR_LSB    = 0;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam int SYNC_RATIO_DEF = 15;
    localparam int CODE_BITS_DEF  = 24;
    localparam int PCT_DIV        = 100;

    localparam logic [TOL_W-1:0]  TOL_RESET  = 7'd60;
    localparam logic [MINP_W-1:0] MINP_RESET = 6'd15;
    localparam logic [PAIR_W-1:0] PAIR_MAX   = '1;

    localparam logic [CFG_IDX_W-1:0] REG_TOL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINP = 2'd1;

    localparam logic [1:0] KIND_SYNC = 2'd0;
    localparam logic [1:0] KIND_HIGH = 2'd1;
    localparam logic [1:0] KIND_LOW  = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [DUR_W-1:0] duration;
        logic             last;
    } item_t;

    typedef struct packed {
        logic               frame_valid;
        logic [NET_W-1:0]   network;
        logic [MAGIC_W-1:0] magic;
        logic [ADDR_W-1:0]  address;
    } result_t;

endpackage

>>> sv/rfpwd_if.sv
// Channel interfaces: pulse input, frame output and configuration write.
interface rfpwd_pulse_if import rfpwd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DUR_W-1:0] duration;
    logic             last_item;

    modport source (output valid, output duration, output last_item, input ready);
    modport sink   (input valid, input duration, input last_item, output ready);
endinterface

interface rfpwd_frame_if import rfpwd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               frame_valid;
    logic [NET_W-1:0]   network;
    logic [MAGIC_W-1:0] magic;
    logic [ADDR_W-1:0]  address;

    modport source (output valid, output frame_valid, output network, output magic,
                    output address, input ready);
    modport sink   (input valid, input frame_valid, input network, input magic,
                    input address, output ready);
endinterface

interface rfpwd_cfg_if import rfpwd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/rf_pulse_width_frame_decoder_unit.sv
// Top level of the pulse-width frame decoder: configuration registers and the three stages.
//
// Returns one frame result for each item marked last_item. While the queue has room it
// takes one pulse duration per clock, a steady rate of one transfer per cycle on the pulse
// channel. After a sync duration the unit length and window pass through a four-stage
// multiply pipeline (divide by SYNC_RATIO, scale by percent, divide by 100, bound
// calculation); the low duration that closes the first pair waits in the two-entry queue
// until the bounds are ready, which can stall the first pair of a capture. A result sits
// in the output register while the next items are taken; results come out in the cycle
// after the closing item leaves the queue. Configuration writes are taken every cycle.
module rf_pulse_width_frame_decoder_unit
    import rfpwd_pkg::*;
#(
    parameter int SYNC_RATIO = SYNC_RATIO_DEF,
    parameter int CODE_BITS  = CODE_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    rfpwd_pulse_if.sink   pulse,
    rfpwd_frame_if.source frame,
    rfpwd_cfg_if.sink     cfg
);

    logic [TOL_W-1:0]  tol_reg;
    logic [MINP_W-1:0] minp_reg;

    logic  push, full, pop, not_empty;
    item_t push_item, pop_item;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg  <= TOL_RESET;
            minp_reg <= MINP_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TOL:  tol_reg  <= cfg.data[TOL_W-1:0];
                REG_MINP: minp_reg <= cfg.data[MINP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    rfpwd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pulse     (pulse),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    rfpwd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_item  (pop_item)
    );

    rfpwd_back #(
        .SYNC_RATIO (SYNC_RATIO),
        .CODE_BITS  (CODE_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .not_empty         (not_empty),
        .q_item            (pop_item),
        .pop               (pop),
        .tolerance_percent (tol_reg),
        .min_pairs         (minp_reg),
        .frame             (frame)
    );

endmodule

>>> sv/rfpwd_front.sv
// Front end: accepts durations and tags each as sync, high or low.
module rfpwd_front
    import rfpwd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rfpwd_pulse_if.sink   pulse,
    input  logic          full,
    output logic          push,
    output item_t         push_item
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;

    assign pulse.ready = ~full;
    assign push        = pulse.valid & ~full;

    always_comb
    begin
        push_item.kind     = phase_reg;
        push_item.duration = pulse.duration;
        push_item.last     = pulse.last_item;
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (push)
        begin
            if (pulse.last_item)
            begin
                phase_next = KIND_SYNC;
            end
            else
            begin
                case (phase_reg)
                    KIND_SYNC: phase_next = KIND_HIGH;
                    KIND_HIGH: phase_next = KIND_LOW;
                    KIND_LOW:  phase_next = KIND_HIGH;
                    default:   phase_next = KIND_SYNC;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= KIND_SYNC;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

>>> sv/rfpwd_queue.sv
// Short queue between the front end and the execution back end.
module rfpwd_queue
    import rfpwd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    item_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/rfpwd_back.sv
// Back end: unit/window pipeline, pair classification, code shift and result register.
module rfpwd_back
    import rfpwd_pkg::*;
#(
    parameter int SYNC_RATIO = SYNC_RATIO_DEF,
    parameter int CODE_BITS  = CODE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              not_empty,
    input  item_t             q_item,
    output logic              pop,
    input  logic [TOL_W-1:0]  tolerance_percent,
    input  logic [MINP_W-1:0] min_pairs,
    rfpwd_frame_if.source     frame
);

    // unit = sync / SYNC_RATIO by reciprocal multiply
    localparam int UNIT_W  = DUR_W - ($clog2(SYNC_RATIO + 1) - 1);
    localparam int SYNC_SH = DUR_W + 6;
    localparam logic [SYNC_SH-1:0] SYNC_MUL =
        SYNC_SH'(((64'd1 << SYNC_SH) + 64'(SYNC_RATIO) - 64'd1) / 64'(SYNC_RATIO));
    // window = unit * percent / 100 by reciprocal multiply
    localparam int P_W    = UNIT_W + TOL_W;
    localparam int PCT_SH = P_W + 7;
    localparam int PM_W   = P_W + 1;
    localparam logic [PM_W-1:0] PCT_MUL =
        PM_W'(((64'd1 << PCT_SH) + 64'(PCT_DIV) - 64'd1) / 64'(PCT_DIV));
    localparam int WIN_W = UNIT_W + 1;
    localparam int CMP_W = DUR_W + 2;

    logic [DUR_W+SYNC_SH-1:0] unit_prod;
    logic [P_W+PM_W-1:0]      win_prod;

    logic [UNIT_W-1:0] unit_reg;
    logic [P_W-1:0]    pct_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [CMP_W-1:0]  lo1_reg, hi1_reg, lo2_reg, hi2_reg;
    logic              unit_vld_reg, unit_vld_next;
    logic              pct_vld_reg, pct_vld_next;
    logic              win_vld_reg, win_vld_next;
    logic              bnd_vld_reg, bnd_vld_next;

    logic [CMP_W-1:0] t1, t2, w;

    logic [DUR_W-1:0]     held_reg;
    logic [CODE_BITS-1:0] code_reg, code_next;
    logic                 failed_reg, failed_next;
    logic [PAIR_W-1:0]    pair_reg, pair_next;

    logic [CMP_W-1:0] h, d;
    logic             is_zero, is_one;
    logic             is_sync, is_low;
    logic             slot_free, can_go, emit;

    result_t out_reg;
    result_t res;
    logic    out_vld_reg, out_vld_next;

    assign is_sync   = (q_item.kind == KIND_SYNC);
    assign is_low    = (q_item.kind == KIND_LOW);
    assign slot_free = ~out_vld_reg | frame.ready;
    assign can_go    = (~is_low | bnd_vld_reg) & (~q_item.last | slot_free);
    assign pop       = not_empty & can_go;
    assign emit      = pop & q_item.last;

    assign unit_prod = (DUR_W+SYNC_SH)'(q_item.duration) * (DUR_W+SYNC_SH)'(SYNC_MUL);
    assign win_prod  = (P_W+PM_W)'(pct_reg) * (P_W+PM_W)'(PCT_MUL);

    assign t1 = CMP_W'(unit_reg);
    assign t2 = CMP_W'(unit_reg) << 1;
    assign w  = CMP_W'(win_reg);

    always_comb
    begin
        unit_vld_next = 1'b0;
        pct_vld_next  = unit_vld_reg;
        win_vld_next  = pct_vld_reg;
        bnd_vld_next  = bnd_vld_reg | win_vld_reg;
        if (pop && is_sync)
        begin
            unit_vld_next = 1'b1;
            pct_vld_next  = 1'b0;
            win_vld_next  = 1'b0;
            bnd_vld_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && is_sync)
        begin
            unit_reg <= unit_prod[SYNC_SH +: UNIT_W];
        end
        if (unit_vld_reg)
        begin
            pct_reg <= P_W'(unit_reg) * P_W'(tolerance_percent);
        end
        if (pct_vld_reg)
        begin
            win_reg <= win_prod[PCT_SH +: WIN_W];
        end
        if (win_vld_reg)
        begin
            lo1_reg <= (t1 > w) ? t1 - w : '0;
            hi1_reg <= t1 + w;
            lo2_reg <= (t2 > w) ? t2 - w : '0;
            hi2_reg <= t2 + w;
        end
    end

    // pair classification, strict windows
    assign h = CMP_W'(held_reg);
    assign d = CMP_W'(q_item.duration);
    assign is_zero = (h > lo1_reg) && (h < hi1_reg) && (d > lo2_reg) && (d < hi2_reg);
    assign is_one  = (h > lo2_reg) && (h < hi2_reg) && (d > lo1_reg) && (d < hi1_reg);

    always_comb
    begin
        code_next   = code_reg;
        failed_next = failed_reg;
        pair_next   = pair_reg;
        if (pop)
        begin
            case (q_item.kind)
                KIND_SYNC:
                begin
                    code_next   = CODE_BITS'(1);
                    failed_next = 1'b0;
                    pair_next   = '0;
                end
                KIND_LOW:
                begin
                    if (!failed_reg)
                    begin
                        if (is_zero || is_one)
                        begin
                            code_next = {code_reg[CODE_BITS-2:0], ~is_zero};
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    if (pair_reg != PAIR_MAX)
                    begin
                        pair_next = pair_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res.frame_valid = ~failed_next && (pair_next >= min_pairs);
        res.network     = res.frame_valid ? code_next[NET_LSB +: NET_W] : '0;
        res.magic       = res.frame_valid ? code_next[MAGIC_LSB +: MAGIC_W] : '0;
        res.address     = res.frame_valid ? code_next[ADDR_LSB +: ADDR_W] : '0;
    end

    always_comb
    begin
        out_vld_next = out_vld_reg & ~frame.ready;
        if (emit)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= res;
        end
        if (pop && q_item.kind == KIND_HIGH)
        begin
            held_reg <= q_item.duration;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_vld_reg <= 1'b0;
            pct_vld_reg  <= 1'b0;
            win_vld_reg  <= 1'b0;
            bnd_vld_reg  <= 1'b0;
            code_reg     <= CODE_BITS'(1);
            failed_reg   <= 1'b0;
            pair_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            unit_vld_reg <= unit_vld_next;
            pct_vld_reg  <= pct_vld_next;
            win_vld_reg  <= win_vld_next;
            bnd_vld_reg  <= bnd_vld_next;
            code_reg     <= code_next;
            failed_reg   <= failed_next;
            pair_reg     <= pair_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    assign frame.valid       = out_vld_reg;
    assign frame.frame_valid = out_reg.frame_valid;
    assign frame.network     = out_reg.network;
    assign frame.magic       = out_reg.magic;
    assign frame.address     = out_reg.address;

    a_sync_restarts_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        pop && is_sync |=> !bnd_vld_reg && unit_vld_reg)
        else $error("bounds not restarted after sync transfer");

    a_pairs_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && is_sync) |=> pair_reg >= $past(pair_reg))
        else $error("pair count dropped without a sync");

    a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg && !(pop && is_sync) |=> failed_reg)
        else $error("failure flag cleared without a sync");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_reg.frame_valid |->
            out_reg.network == '0 && out_reg.magic == '0 && out_reg.address == '0)
        else $error("invalid frame carries non-zero fields");

endmodule
